/* rtl/lspb_pkg.sv */
// ----------------------------------------------------------------------------
// lspb_pkg
// Shared types and constants for the lidar sector proximity brake unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lspb_pkg;

    localparam int NUM_SECTORS = 8;

    typedef logic [11:0]        t_angle_raw;
    typedef logic signed [12:0] t_angle;
    typedef logic [15:0]        t_dist;
    typedef logic [2:0]         t_grade;
    typedef logic [2:0]         t_sector;
    typedef logic [1:0]         t_hits;

    localparam t_sector SEC_FRONT       = 3'd0;
    localparam t_sector SEC_BACK        = 3'd1;
    localparam t_sector SEC_LEFT        = 3'd2;
    localparam t_sector SEC_RIGHT       = 3'd3;
    localparam t_sector SEC_FRONT_RIGHT = 3'd4;
    localparam t_sector SEC_BACK_RIGHT  = 3'd5;
    localparam t_sector SEC_BACK_LEFT   = 3'd6;
    localparam t_sector SEC_FRONT_LEFT  = 3'd7;

    localparam t_angle ANG_HALF_TURN = 13'sd1800;
    localparam t_angle ANG_1575      = 13'sd1575;
    localparam t_angle ANG_1125      = 13'sd1125;
    localparam t_angle ANG_675       = 13'sd675;
    localparam t_angle ANG_225       = 13'sd225;
    localparam t_angle ANG_AXIS      = 13'sd300;

    localparam t_dist DIST_FAR      = 16'd450;
    localparam t_dist DIST_G1       = 16'd400;
    localparam t_dist DIST_G2       = 16'd350;
    localparam t_dist DIST_G3       = 16'd300;
    localparam t_dist DIST_NEAR     = 16'd200;
    localparam t_dist HIT_MIN       = 16'd100;
    localparam t_dist HIT_MAX_SIDE  = 16'd200;
    localparam t_dist HIT_MAX_AXIS  = 16'd220;

    localparam t_hits HITS_BRAKE = 2'd2;

    typedef struct packed {
        t_angle_raw angle;
        t_dist      dist_mm;
        logic       last;
    } t_point;

    typedef struct packed {
        t_sector sector;
        t_grade  grade;
        logic    hit;
    } t_class;

    typedef struct packed {
        t_grade [NUM_SECTORS-1:0] grades;
        logic                     brake;
        logic                     brake_changed;
    } t_result;

endpackage

`default_nettype wire

/* rtl/lspb_classify.sv */
// ----------------------------------------------------------------------------
// lspb_classify
// Maps one registered lidar point to its sector, distance grade and hit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lspb_classify
    import lspb_pkg::*;
(
    input  wire t_point i_point,
    output t_class      o_class
);

    t_angle a;
    t_dist  d;
    logic   on_axis;

    always_comb begin
        d = i_point.dist_mm;
        if (i_point.angle == '0) begin
            a = '0;
        end else begin
            a = ANG_HALF_TURN - $signed({1'b0, i_point.angle});
        end

        if ((a <= -ANG_1575 && a >= -ANG_HALF_TURN) || (a >= ANG_1575 && a <= ANG_HALF_TURN)) begin
            o_class.sector = SEC_FRONT;
        end else if (a > -ANG_1575 && a <= -ANG_1125) begin
            o_class.sector = SEC_FRONT_LEFT;
        end else if (a <= ANG_1575 && a >= ANG_1125) begin
            o_class.sector = SEC_FRONT_RIGHT;
        end else if (a >= -ANG_1125 && a <= -ANG_675) begin
            o_class.sector = SEC_LEFT;
        end else if (a < ANG_1125 && a >= ANG_675) begin
            o_class.sector = SEC_RIGHT;
        end else if (a > -ANG_675 && a <= -ANG_225) begin
            o_class.sector = SEC_BACK_LEFT;
        end else if (a <= ANG_675 && a >= ANG_225) begin
            o_class.sector = SEC_BACK_RIGHT;
        end else begin
            o_class.sector = SEC_BACK;
        end

        if (!(d < DIST_FAR && d > DIST_NEAR)) begin
            o_class.grade = 3'd0;
        end else if (d < DIST_G3) begin
            o_class.grade = 3'd4;
        end else if (d < DIST_G2) begin
            o_class.grade = 3'd3;
        end else if (d < DIST_G1) begin
            o_class.grade = 3'd2;
        end else begin
            o_class.grade = 3'd1;
        end

        on_axis = (a <= ANG_AXIS) && (a >= -ANG_AXIS);
        if (on_axis) begin
            o_class.hit = (d > HIT_MIN) && (d < HIT_MAX_AXIS);
        end else begin
            o_class.hit = (d > HIT_MIN) && (d < HIT_MAX_SIDE);
        end
    end

endmodule

`default_nettype wire

/* rtl/lspb_scan_acc.sv */
// ----------------------------------------------------------------------------
// lspb_scan_acc
// Holds the per-scan sector grades, hit count, brake state and override
// register, and registers one result transaction at each end of scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lspb_scan_acc
    import lspb_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_data,
    input  wire         i_move,
    input  wire         i_last,
    input  wire t_class i_class,
    input  wire         i_out_stall,
    output logic        o_out_valid,
    output t_result     o_result,
    output logic        o_out_hold
);

    t_grade [NUM_SECTORS-1:0] r_grades;
    t_grade [NUM_SECTORS-1:0] n_grades;
    t_hits                    r_hits;
    t_hits                    n_hits;
    logic                     r_brake;
    logic                     r_override;
    logic                     r_out_valid;
    t_result                  r_result;
    t_result                  n_result;
    logic                     n_brake;

    always_comb begin
        n_grades = r_grades;
        n_hits   = r_hits;
        if (!r_override) begin
            for (int k = 0; k < NUM_SECTORS; k++) begin
                if (i_class.sector == t_sector'(k) && r_grades[k] < i_class.grade) begin
                    n_grades[k] = i_class.grade;
                end
            end
            if (i_class.hit && r_hits < HITS_BRAKE) begin
                n_hits = r_hits + 2'd1;
            end
        end

        n_brake = (n_hits >= HITS_BRAKE);
        if (r_override) begin
            n_result = '0;
        end else begin
            n_result.grades        = n_grades;
            n_result.brake         = n_brake;
            n_result.brake_changed = (n_brake != r_brake);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grades    <= '0;
            r_hits      <= '0;
            r_brake     <= 1'b0;
            r_override  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_override <= i_cfg_data;
                if (i_cfg_data) begin
                    r_brake <= 1'b0;
                end
            end

            if (i_move) begin
                if (i_last) begin
                    r_grades <= '0;
                    r_hits   <= '0;
                    r_brake  <= n_result.brake;
                end else begin
                    r_grades <= n_grades;
                    r_hits   <= n_hits;
                end
            end

            if (i_move && i_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move && i_last) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_out_hold  = r_out_valid && i_out_stall;

endmodule

`default_nettype wire

/* rtl/lidar_sector_proximity_brake_unit.sv */
// ----------------------------------------------------------------------------
// lidar_sector_proximity_brake_unit
// Reduces a stream of lidar points to eight sector grades and a brake flag.
// ----------------------------------------------------------------------------
// Each input transaction is taken into a point register and from there
// classified and, unless the override is set, folded into the sector grades
// and hit count, so a point can be accepted in every cycle while the input
// is not stalled. A point marked as the last of a scan, once it moves on
// from the point register, loads one result transaction into an output
// register; the input stalls only while a finished end-of-scan point waits
// behind a result that the receiver has not yet taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_sector_proximity_brake_unit
    import lspb_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [11:0] i_scan_angle,
    input  wire  [15:0] i_distance_mm,
    input  wire         i_last_point,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_front_level,
    output logic [2:0]  o_back_level,
    output logic [2:0]  o_left_level,
    output logic [2:0]  o_right_level,
    output logic [2:0]  o_front_right_level,
    output logic [2:0]  o_back_right_level,
    output logic [2:0]  o_back_left_level,
    output logic [2:0]  o_front_left_level,
    output logic        o_brake,
    output logic        o_brake_changed
);

    logic    r_p_valid;
    t_point  r_p;
    logic    blocked;
    logic    move;
    logic    out_hold;
    t_class  pt_class;
    t_result result;

    assign blocked    = r_p_valid && r_p.last && out_hold;
    assign move       = r_p_valid && !blocked;
    assign o_in_stall = blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (!blocked) begin
            r_p_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !blocked) begin
            r_p.angle   <= i_scan_angle;
            r_p.dist_mm <= i_distance_mm;
            r_p.last    <= i_last_point;
        end
    end

    lspb_classify u_classify (
        .i_point (r_p),
        .o_class (pt_class)
    );

    lspb_scan_acc u_scan_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_move      (move),
        .i_last      (r_p.last),
        .i_class     (pt_class),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result),
        .o_out_hold  (out_hold)
    );

    assign o_front_level       = result.grades[SEC_FRONT];
    assign o_back_level        = result.grades[SEC_BACK];
    assign o_left_level        = result.grades[SEC_LEFT];
    assign o_right_level       = result.grades[SEC_RIGHT];
    assign o_front_right_level = result.grades[SEC_FRONT_RIGHT];
    assign o_back_right_level  = result.grades[SEC_BACK_RIGHT];
    assign o_back_left_level   = result.grades[SEC_BACK_LEFT];
    assign o_front_left_level  = result.grades[SEC_FRONT_LEFT];
    assign o_brake             = result.brake;
    assign o_brake_changed     = result.brake_changed;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lidar sector proximity brake unit.
// ----------------------------------------------------------------------------
// Streams lidar points, grouped into scans, through the unit with random
// gaps on both sides. The bench covers boundary angles and distances and
// toggles the override register between phases. Each end-of-scan transaction
// is predicted by a scoreboard that keeps its own sector grades, hit count
// and stored brake. Every result transaction is compared field by field with
// the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lspb_pkg::*;

    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRESSURE_AT    = 300;
    localparam int HOLD_CYCLES    = 80;

    class scan_report_board;
        bit      override_on;
        t_grade  sector_peak [NUM_SECTORS] = '{default: '0};
        t_hits   close_count = '0;
        bit      brake_last;
        t_result pending_reports [$];
        int      points_taken;
        int      reports_checked;
        int      brakes_seen;
        int      mismatches;
        string   sector_names [NUM_SECTORS] = '{"front", "back", "left", "right",
            "front_right", "back_right", "back_left", "front_left"};

        function void clear_scan();
            foreach (sector_peak[k]) sector_peak[k] = '0;
            close_count = '0;
        endfunction

        function void set_override(bit v);
            override_on = v;
            if (v) brake_last = 1'b0;
        endfunction

        function t_grade grade_for(t_dist d);
            if (!(d < DIST_FAR && d > DIST_NEAR)) return 3'd0;
            if (d < DIST_G3) return 3'd4;
            if (d < DIST_G2) return 3'd3;
            if (d < DIST_G1) return 3'd2;
            return 3'd1;
        endfunction

        function t_sector sector_for(t_angle a);
            if ((a <= -ANG_1575 && a >= -ANG_HALF_TURN) ||
                (a >= ANG_1575 && a <= ANG_HALF_TURN)) return SEC_FRONT;
            if (a > -ANG_1575 && a <= -ANG_1125) return SEC_FRONT_LEFT;
            if (a <= ANG_1575 && a >= ANG_1125) return SEC_FRONT_RIGHT;
            if (a >= -ANG_1125 && a <= -ANG_675) return SEC_LEFT;
            if (a < ANG_1125 && a >= ANG_675) return SEC_RIGHT;
            if (a > -ANG_675 && a <= -ANG_225) return SEC_BACK_LEFT;
            if (a <= ANG_675 && a >= ANG_225) return SEC_BACK_RIGHT;
            return SEC_BACK;
        endfunction

        function void fold_point(t_angle_raw s, t_dist d, bit last);
            t_angle  a;
            t_sector sec;
            t_grade  g;
            bit      hit;
            t_result r;
            points_taken++;
            if (!override_on) begin
                a = 13'sd0 - $signed({1'b0, s});
                if (a < 0) a = a + ANG_HALF_TURN;
                sec = sector_for(a);
                g = grade_for(d);
                if (sector_peak[sec] < g) sector_peak[sec] = g;
                if (a > ANG_AXIS || a < -ANG_AXIS) begin
                    hit = d > HIT_MIN && d < HIT_MAX_SIDE;
                end else begin
                    hit = d > HIT_MIN && d < HIT_MAX_AXIS;
                end
                if (hit && close_count < HITS_BRAKE) close_count++;
            end
            if (!last) return;
            r = '0;
            if (override_on) begin
                brake_last = 1'b0;
            end else begin
                for (int k = 0; k < NUM_SECTORS; k++) r.grades[k] = sector_peak[k];
                r.brake = close_count >= HITS_BRAKE;
                r.brake_changed = r.brake != brake_last;
                brake_last = r.brake;
            end
            clear_scan();
            pending_reports = {pending_reports, r};
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void check_report(t_result got);
            t_result want;
            if (pending_reports.size() == 0) begin
                flag("MISMATCH: result transaction with no prediction waiting");
                return;
            end
            want = pending_reports.pop_front();
            reports_checked++;
            if (want.brake) brakes_seen++;
            for (int k = 0; k < NUM_SECTORS; k++) begin
                if (got.grades[k] !== want.grades[k])
                    flag($sformatf("MISMATCH result %0d %s_level: expected %0d, got %0d",
                        reports_checked, sector_names[k], want.grades[k], got.grades[k]));
            end
            if (got.brake !== want.brake)
                flag($sformatf("MISMATCH result %0d brake: expected %0d, got %0d",
                    reports_checked, want.brake, got.brake));
            if (got.brake_changed !== want.brake_changed)
                flag($sformatf("MISMATCH result %0d brake_changed: expected %0d, got %0d",
                    reports_checked, want.brake_changed, got.brake_changed));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [11:0] i_scan_angle;
    logic [15:0] i_distance_mm;
    logic        i_last_point;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_front_level;
    logic [2:0]  o_back_level;
    logic [2:0]  o_left_level;
    logic [2:0]  o_right_level;
    logic [2:0]  o_front_right_level;
    logic [2:0]  o_back_right_level;
    logic [2:0]  o_back_left_level;
    logic [2:0]  o_front_left_level;
    logic        o_brake;
    logic        o_brake_changed;

    scan_report_board sb = new;
    bit calm = 1'b0;
    bit pressure_done = 1'b0;
    int hold_left = 0;
    int items_sent = 0;
    int idle_run = 0;
    int angle_edges [$] = '{0, 1, 224, 225, 226, 674, 675, 676, 1124, 1125, 1126,
        1499, 1500, 1501, 1574, 1575, 1576, 1799, 1800, 1801, 2024, 2025, 2026,
        2099, 2100, 2101, 2474, 2475, 2476, 2924, 2925, 2926, 3374, 3375, 3376,
        3599, 3600, 3601, 4095};
    int dist_edges [$] = '{0, 99, 100, 101, 199, 200, 201, 219, 220, 221, 299, 300,
        301, 349, 350, 351, 399, 400, 401, 449, 450, 451, 65535};

    lidar_sector_proximity_brake_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_scan_angle        (i_scan_angle),
        .i_distance_mm       (i_distance_mm),
        .i_last_point        (i_last_point),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_front_level       (o_front_level),
        .o_back_level        (o_back_level),
        .o_left_level        (o_left_level),
        .o_right_level       (o_right_level),
        .o_front_right_level (o_front_right_level),
        .o_back_right_level  (o_back_right_level),
        .o_back_left_level   (o_back_left_level),
        .o_front_left_level  (o_front_left_level),
        .o_brake             (o_brake),
        .o_brake_changed     (o_brake_changed)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.fold_point(i_scan_angle, i_distance_mm, i_last_point);
            if (o_out_valid && !i_out_stall) begin
                got.grades[SEC_FRONT]       = o_front_level;
                got.grades[SEC_BACK]        = o_back_level;
                got.grades[SEC_LEFT]        = o_left_level;
                got.grades[SEC_RIGHT]       = o_right_level;
                got.grades[SEC_FRONT_RIGHT] = o_front_right_level;
                got.grades[SEC_BACK_RIGHT]  = o_back_right_level;
                got.grades[SEC_BACK_LEFT]   = o_back_left_level;
                got.grades[SEC_FRONT_LEFT]  = o_front_left_level;
                got.brake                   = o_brake;
                got.brake_changed           = o_brake_changed;
                sb.check_report(got);
            end
        end
    end

    // The receiver holds off once for a long stretch so that the unit backs up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!pressure_done && sb.points_taken >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 13);
            end
        end
    end

    initial begin
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_point(int s, int d, bit last);
        calm = items_sent >= 800 && items_sent < 950;
        if (!calm && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_scan_angle  <= s[11:0];
        i_distance_mm <= d[15:0];
        i_last_point  <= last;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_override(bit v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_override(v);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic int pick_angle();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25) return angle_edges[$urandom_range(angle_edges.size() - 1)];
        if (roll < 80) return $urandom_range(3599);
        if (roll < 90) return $urandom_range(3600, 4095);
        return $urandom_range(4095);
    endfunction

    function automatic int pick_dist(bit quiet);
        int roll;
        roll = $urandom_range(99);
        if (quiet) return (roll < 70) ? $urandom_range(220, 600) : $urandom_range(220, 65535);
        if (roll < 30) return dist_edges[$urandom_range(dist_edges.size() - 1)];
        if (roll < 80) return $urandom_range(500);
        return $urandom_range(65535);
    endfunction

    task automatic send_scans(int n_points);
        int  sent;
        int  len;
        bit  quiet;
        sent = 0;
        while (sent < n_points) begin
            len = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            quiet = $urandom_range(2) == 0;
            for (int k = 0; k < len; k++) begin
                send_point(pick_angle(), pick_dist(quiet), k == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= 1'b0;
        i_in_valid    <= 1'b0;
        i_scan_angle  <= '0;
        i_distance_mm <= '0;
        i_last_point  <= 1'b0;
        i_out_stall   <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_override(1'b0);

        send_point(0, 0, 0);
        send_point(225, 299, 0);
        send_point(226, 300, 0);
        send_point(675, 349, 0);
        send_point(676, 350, 0);
        send_point(1125, 399, 0);
        send_point(1126, 400, 0);
        send_point(1500, 201, 0);
        send_point(2100, 219, 0);
        send_point(2101, 199, 0);
        send_point(2475, 449, 0);
        send_point(2925, 450, 0);
        send_point(3375, 401, 1);
        send_point(3600, 65535, 0);
        send_point(4095, 250, 0);
        send_point(3601, 101, 0);
        send_point(1800, 100, 0);
        send_point(1, 220, 1);
        send_point(2024, 199, 1);
        settle();

        send_scans(520);
        settle();

        // An open scan with two hits is left pending when the override is set.
        send_point(1500, 150, 0);
        send_point(1500, 150, 0);
        send_point(250, 260, 0);
        settle();
        write_override(1'b1);
        send_point(1500, 150, 0);
        send_point(0, 300, 1);
        settle();
        send_scans(90);
        settle();
        write_override(1'b0);

        // Setting the override alone must clear the stored brake.
        send_point(1500, 150, 0);
        send_point(1500, 150, 1);
        settle();
        write_override(1'b1);
        write_override(1'b0);
        send_point(1500, 150, 0);
        send_point(1500, 150, 1);
        settle();

        send_scans(450);
        settle();

        if (sb.pending_reports.size() != 0)
            sb.flag($sformatf("MISMATCH: %0d predicted results never arrived",
                sb.pending_reports.size()));
        $display("Run covered %0d points with the override both clear and set,", sb.points_taken);
        $display("and %0d scan results, %0d of them with the brake set; %0d mismatches.",
            sb.reports_checked, sb.brakes_seen, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/lspb_pkg.sv
rtl/lspb_classify.sv
rtl/lspb_scan_acc.sv
rtl/lidar_sector_proximity_brake_unit.sv
tb/sv/testbench.sv
